>>> hdl/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Types and constants shared by the half/single float converter files.
// ----------------------------------------------------------------------------
package hsfc_pkg;

   // Conversion direction carried in tuser.
   localparam logic DIR_WIDEN  = 1'b0;  // binary16 to binary32
   localparam logic DIR_NARROW = 1'b1;  // binary32 to binary16

   // Exponent difference between the two biases (127 - 15).
   localparam logic [7:0] BIAS_DELTA    = 8'd112;
   // Single exponents below this go to signed zero in half.
   localparam logic [7:0] NARROW_ZERO_LIM = 8'd102;
   // Single exponents at or below this give a half subnormal.
   localparam logic [7:0] NARROW_SUB_LIM  = 8'd112;
   // Single exponents at or above this overflow to half infinity.
   localparam logic [7:0] NARROW_INF_LIM  = 8'd143;
   // Shift base for half subnormals: 14 + 112.
   localparam logic [7:0] NARROW_SH_BASE  = 8'd126;

   localparam logic [7:0] SINGLE_EXP_MAX = 8'hFF;
   localparam logic [4:0] HALF_EXP_MAX   = 5'h1F;

   localparam int HALF_FRAC_W   = 10;
   localparam int SINGLE_FRAC_W = 23;
   localparam int SIG_W         = 24;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_SUB,
      KIND_SPECIAL,
      KIND_NORMAL
   } kind_type;

   // Word after classification.
   typedef struct packed {
      logic                  dir;
      logic                  sign;
      kind_type              kind;
      logic [7:0]            expo;
      logic [4:0]            shamt;
      logic [SIG_W-1:0]      mant;
   } cls_type;

   // Word after the fraction shift.
   typedef struct packed {
      logic                  dir;
      logic                  sign;
      logic [7:0]            expo;
      logic [HALF_FRAC_W-1:0] frac;
   } shf_type;

endpackage

>>> hdl/hsfc_lzc.sv
// ----------------------------------------------------------------------------
// hsfc_lzc
// Leading-zero count of a 10-bit half fraction.
// ----------------------------------------------------------------------------
module hsfc_lzc (
   input  logic [9:0] value,
   output logic [3:0] count
);
   import hsfc_pkg::*;

   // The highest set bit wins; an all-zero value reports ten.
   always_comb begin
      count = 4'd10;
      for (int i = 0; i < HALF_FRAC_W; i++) begin
         if (value[i]) begin
            count = 4'(HALF_FRAC_W - 1 - i);
         end
      end
   end

endmodule

>>> hdl/half_single_float_converter_unit.sv
// ----------------------------------------------------------------------------
// half_single_float_converter_unit
// Converts IEEE 754 values between binary16 and binary32 in a three-stage
// pipeline.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the req channel carries a source value in req_tdata and the
// direction in req_tuser (0: half to single, 1: single to half). A half
// source uses bits 15..0; bits 31..16 are ignored. Every accepted word
// yields exactly one rsp word, in order. A half result sits in bits 15..0
// of rsp_tdata with the upper bits zero. Single to half truncates toward
// zero; overflow and single NaN become signed infinity, and values too
// small become signed zero.
// Classification, fraction shift and result assembly each end in a
// register, and a word passes the three registers in that order before
// rsp_tvalid rises. One word can enter every cycle while rsp_tready stays
// high. When the receiver holds rsp_tready low, each stage keeps its word
// and only the empty stages fill, so req_tready drops once all three
// stages hold words; nothing is lost or repeated. Reset empties the
// pipeline; the data registers are not cleared.
// ----------------------------------------------------------------------------
module half_single_float_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_bits
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result_bits
);
   import hsfc_pkg::*;

   // Stage valid bits and their ready chain.
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   cls_type     cls_in, cls_ff;
   shf_type     shf_in, shf_ff;
   logic [31:0] res_in, res_ff;

   logic [3:0]  lz;

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_tready = rdy1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = res_ff;

   // Leading zeros of a half fraction, used to normalize subnormals.
   hsfc_lzc u_lzc (
      .value (req_tdata[9:0]),
      .count (lz)
   );

   // Stage 1: classify the source and work out the target exponent and
   // the shift that the fraction still needs.
   always_comb begin
      logic [4:0] hex;
      logic [7:0] sex;
      hex = req_tdata[14:10];
      sex = req_tdata[30:23];

      cls_in       = '0;
      cls_in.dir   = req_tuser;
      if (req_tuser == DIR_WIDEN) begin
         cls_in.sign = req_tdata[15];
         cls_in.mant = {14'd0, req_tdata[9:0]};
         if (hex == 5'd0) begin
            if (req_tdata[9:0] == 10'd0) begin
               cls_in.kind = KIND_ZERO;
            end else begin
               // The fraction moves up until its top bit reaches the
               // hidden position; the exponent drops by the same amount.
               cls_in.kind  = KIND_SUB;
               cls_in.expo  = BIAS_DELTA - {4'd0, lz};
               cls_in.shamt = {1'b0, lz} + 5'd1;
            end
         end else if (hex == HALF_EXP_MAX) begin
            cls_in.kind = KIND_SPECIAL;
            cls_in.expo = SINGLE_EXP_MAX;
         end else begin
            cls_in.kind = KIND_NORMAL;
            cls_in.expo = {3'd0, hex} + BIAS_DELTA;
         end
      end else begin
         cls_in.sign = req_tdata[31];
         cls_in.mant = {1'b1, req_tdata[22:0]};
         if (sex < NARROW_ZERO_LIM) begin
            cls_in.kind = KIND_ZERO;
         end else if (sex <= NARROW_SUB_LIM) begin
            // Right shift of the full significand, 14 to 24 places.
            cls_in.kind  = KIND_SUB;
            cls_in.shamt = 5'(NARROW_SH_BASE - sex);
         end else if (sex >= NARROW_INF_LIM) begin
            cls_in.kind = KIND_SPECIAL;
            cls_in.expo = {3'd0, HALF_EXP_MAX};
         end else begin
            cls_in.kind = KIND_NORMAL;
            cls_in.expo = sex - BIAS_DELTA;
         end
      end
   end

   // Stage 2: produce the 10 fraction bits that both formats share.
   always_comb begin
      logic [SIG_W-1:0] lsh;
      logic [SIG_W-1:0] rsh;
      lsh = cls_ff.mant << cls_ff.shamt;
      rsh = cls_ff.mant >> cls_ff.shamt;

      shf_in.dir  = cls_ff.dir;
      shf_in.sign = cls_ff.sign;
      shf_in.expo = cls_ff.expo;
      unique case (cls_ff.kind)
         KIND_ZERO: begin
            shf_in.frac = '0;
         end
         KIND_SUB: begin
            shf_in.frac = (cls_ff.dir == DIR_WIDEN) ? lsh[9:0] : rsh[9:0];
         end
         KIND_SPECIAL: begin
            // Infinity and NaN keep their payload going up, lose it going down.
            shf_in.frac = (cls_ff.dir == DIR_WIDEN) ? cls_ff.mant[9:0] : '0;
         end
         KIND_NORMAL: begin
            shf_in.frac = (cls_ff.dir == DIR_WIDEN) ? cls_ff.mant[9:0]
                                                    : cls_ff.mant[22:13];
         end
         default: begin
            shf_in.frac = '0;
         end
      endcase
   end

   // Stage 3: pack the result word in the target format.
   always_comb begin
      if (shf_ff.dir == DIR_WIDEN) begin
         res_in = {shf_ff.sign, shf_ff.expo, shf_ff.frac, 13'd0};
      end else begin
         res_in = {16'd0, shf_ff.sign, shf_ff.expo[4:0], shf_ff.frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_tvalid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         cls_ff <= cls_in;
      end
      if (rdy2 && v1_ff) begin
         shf_ff <= shf_in;
      end
      if (rdy3 && v2_ff) begin
         res_ff <= res_in;
      end
   end

endmodule
